/* rtl/cmc_pkg.sv */
// Shared types, character codes and helper functions for the hex command
// memory console. No dependencies; used by the top level and its checker.
package cmc_pkg;

    // Store and line geometry
    localparam int STORE_DEPTH_DEF = 1024;
    localparam int LINE_SLOTS      = 9;
    localparam int CNT_W           = 4;
    localparam logic [CNT_W-1:0] COUNT_MAX = 4'd15;
    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    // Command characters
    localparam logic [7:0] CH_E     = 8'h65;  // 'e'
    localparam logic [7:0] CH_R     = 8'h72;  // 'r'
    localparam logic [7:0] CH_W     = 8'h77;  // 'w'

    // Answer characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_UP_E  = 8'h45;  // 'E'
    localparam logic [7:0] CH_UP_O  = 8'h4F;  // 'O'
    localparam logic [7:0] CH_UP_K  = 8'h4B;  // 'K'
    localparam logic [7:0] CH_BANG  = 8'h21;  // '!'
    localparam logic [7:0] CH_AT    = 8'h40;  // '@'
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Kind of answer being sent
    typedef enum logic [1:0] {
        RESP_EMPTY,
        RESP_READ,
        RESP_OK,
        RESP_ERR
    } resp_kind_t;

    // Control state: erase sweep after reset, then normal operation
    typedef enum logic {
        CTL_CLEAR,
        CTL_RUN
    } ctl_state_t;

    // Decode one uppercase hex digit: bit 4 = valid, bits 3:0 = value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            res = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            res = {1'b1, 4'(c - 8'h37)};
        end
        return res;
    endfunction

    // Encode one nibble as an uppercase hex character
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] res;
        if (nib > 4'd9)
        begin
            res = 8'h37 + {4'd0, nib};
        end
        else
        begin
            res = 8'h30 + {4'd0, nib};
        end
        return res;
    endfunction

endpackage

/* rtl/hex_command_memory_console.sv */
// Latency: a line-end beat is decoded when taken; the answer starts on the
// next cycle and runs 6, 8 or 10 beats, one per cycle while the sink takes them.
// Throughput: characters are taken every cycle, also while an answer drains;
// a line end waits until the previous answer has finished (one store port).
// Reset: control clears at once, then a sweep writes 0xFF to all STORE_DEPTH
// entries, one per cycle, with s_axis_tready held low. Depends on cmc_pkg.
module hex_command_memory_console #(
    parameter int STORE_DEPTH = cmc_pkg::STORE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_char
    input  logic       s_axis_tlast,   // line_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] tx_char
    output logic       m_axis_tlast    // tx_last
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);

    // Byte store and its read register
    logic [7:0] store_mem [STORE_DEPTH];
    logic [7:0] rdata_reg;

    // Line buffer (no reset, only entries below the count are decoded)
    logic [7:0] line_buf_reg [cmc_pkg::LINE_SLOTS];
    logic [cmc_pkg::CNT_W-1:0] count_reg, count_next;

    // Control
    cmc_pkg::ctl_state_t state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic busy_reg, busy_next;
    logic [3:0] idx_reg, idx_next;
    cmc_pkg::resp_kind_t kind_reg, kind_next;

    logic clearing;
    logic in_fire, char_fire, end_fire, out_fire;

    // Decode signals
    logic [4:0] d2, d3, d4, d5, d7, d8;
    logic [15:0] line_addr;
    logic addr_ok, pairs_ok, data_ok;
    logic [7:0] line_data;
    cmc_pkg::resp_kind_t dec_kind;

    // Memory port
    logic mem_we, mem_re;
    logic [AW-1:0] mem_addr;
    logic [7:0] mem_wdata;

    // Answer formatting
    logic [3:0] body_len, body_pos, tail_pos;

    // Next control state
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        case (state_reg)
            cmc_pkg::CTL_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = cmc_pkg::CTL_RUN;
                end
            end
            cmc_pkg::CTL_RUN:
            begin
                state_next = cmc_pkg::CTL_RUN;
            end
            default:
            begin
                state_next = cmc_pkg::CTL_CLEAR;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        case (state_reg)
            cmc_pkg::CTL_CLEAR: clearing = 1'b1;
            cmc_pkg::CTL_RUN:   clearing = 1'b0;
            default:            clearing = 1'b1;
        endcase
    end

    // Interlock: a line end waits for the current answer to drain
    assign s_axis_tready = !clearing && !(busy_reg && s_axis_tlast);
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign char_fire = in_fire && !s_axis_tlast;
    assign end_fire  = in_fire && s_axis_tlast;
    assign out_fire  = m_axis_tvalid && m_axis_tready;

    // Decode the buffered line
    always_comb
    begin
        d2 = cmc_pkg::hex_digit(line_buf_reg[2]);
        d3 = cmc_pkg::hex_digit(line_buf_reg[3]);
        d4 = cmc_pkg::hex_digit(line_buf_reg[4]);
        d5 = cmc_pkg::hex_digit(line_buf_reg[5]);
        d7 = cmc_pkg::hex_digit(line_buf_reg[7]);
        d8 = cmc_pkg::hex_digit(line_buf_reg[8]);
        line_addr = {d2[3:0], d3[3:0], d4[3:0], d5[3:0]};
        line_data = {d7[3:0], d8[3:0]};
        addr_ok   = ({1'b0, line_addr} < 17'(STORE_DEPTH));
        pairs_ok  = d2[4] && d3[4] && d4[4] && d5[4];
        data_ok   = d7[4] && d8[4];
        dec_kind  = cmc_pkg::RESP_ERR;
        if (count_reg == '0)
        begin
            dec_kind = cmc_pkg::RESP_EMPTY;
        end
        else if (line_buf_reg[0] == cmc_pkg::CH_E && count_reg >= 4'd6 &&
                 count_reg <= 4'(cmc_pkg::LINE_SLOTS) && pairs_ok && addr_ok)
        begin
            if (line_buf_reg[1] == cmc_pkg::CH_R && count_reg == 4'd6)
            begin
                dec_kind = cmc_pkg::RESP_READ;
            end
            else if (line_buf_reg[1] == cmc_pkg::CH_W &&
                     count_reg == 4'(cmc_pkg::LINE_SLOTS) && data_ok)
            begin
                dec_kind = cmc_pkg::RESP_OK;
            end
        end
    end

    // Memory port: erase sweep, or the access of a decoded line
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = line_addr[AW-1:0];
        mem_wdata = line_data;
        if (clearing)
        begin
            mem_we    = 1'b1;
            mem_addr  = clr_addr_reg;
            mem_wdata = cmc_pkg::ERASED_BYTE;
        end
        else if (end_fire)
        begin
            mem_we = (dec_kind == cmc_pkg::RESP_OK);
            mem_re = (dec_kind == cmc_pkg::RESP_READ);
        end
    end

    // Byte store: one synchronous port, registered read data
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= store_mem[mem_addr];
        end
    end

    // Buffer characters of the current line
    always_ff @(posedge clk)
    begin
        if (char_fire && count_reg < 4'(cmc_pkg::LINE_SLOTS))
        begin
            line_buf_reg[count_reg] <= s_axis_tdata;
        end
    end

    // Character count: saturate, clear at line end
    always_comb
    begin
        count_next = count_reg;
        if (end_fire)
        begin
            count_next = '0;
        end
        else if (char_fire && count_reg < cmc_pkg::COUNT_MAX)
        begin
            count_next = count_reg + 4'd1;
        end
    end

    // Answer sequencer: load on line end, advance on each output beat
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        kind_next = kind_reg;
        if (end_fire)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
            kind_next = dec_kind;
        end
        else if (out_fire)
        begin
            idx_next = idx_reg + 4'd1;
            if (m_axis_tlast)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cmc_pkg::CTL_CLEAR;
            clr_addr_reg <= '0;
            count_reg    <= '0;
            busy_reg     <= 1'b0;
            idx_reg      <= '0;
            kind_reg     <= cmc_pkg::RESP_EMPTY;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            count_reg    <= count_next;
            busy_reg     <= busy_next;
            idx_reg      <= idx_next;
            kind_reg     <= kind_next;
        end
    end

    // Format the answer character at the current position
    always_comb
    begin
        case (kind_reg)
            cmc_pkg::RESP_EMPTY: body_len = 4'd0;
            cmc_pkg::RESP_ERR:   body_len = 4'd4;
            default:             body_len = 4'd2;
        endcase
        body_pos = idx_reg - 4'd2;
        tail_pos = body_pos - body_len;
        if (idx_reg == 4'd0)
        begin
            m_axis_tdata = cmc_pkg::CH_CR;
        end
        else if (idx_reg == 4'd1)
        begin
            m_axis_tdata = cmc_pkg::CH_LF;
        end
        else if (body_pos < body_len)
        begin
            case (kind_reg)
                cmc_pkg::RESP_READ:
                    m_axis_tdata = (body_pos == 4'd0) ? cmc_pkg::hex_char(rdata_reg[7:4])
                                                      : cmc_pkg::hex_char(rdata_reg[3:0]);
                cmc_pkg::RESP_OK:
                    m_axis_tdata = (body_pos == 4'd0) ? cmc_pkg::CH_UP_O : cmc_pkg::CH_UP_K;
                default:
                begin
                    case (body_pos)
                        4'd0:    m_axis_tdata = cmc_pkg::CH_UP_E;
                        4'd1:    m_axis_tdata = cmc_pkg::CH_R;
                        4'd2:    m_axis_tdata = cmc_pkg::CH_R;
                        default: m_axis_tdata = cmc_pkg::CH_BANG;
                    endcase
                end
            endcase
        end
        else
        begin
            case (tail_pos)
                4'd0:    m_axis_tdata = cmc_pkg::CH_CR;
                4'd1:    m_axis_tdata = cmc_pkg::CH_LF;
                4'd2:    m_axis_tdata = cmc_pkg::CH_AT;
                default: m_axis_tdata = cmc_pkg::CH_SPACE;
            endcase
        end
        m_axis_tlast = (tail_pos == 4'd3);
    end

    assign m_axis_tvalid = busy_reg;

endmodule

/* rtl/cmc_checker.sv */
// Port-level checker for the hex command memory console, bound to the top.
// Depends on cmc_pkg and the top level's port list.
module cmc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,   // [7:0] rx_char
    input logic       s_axis_tlast,   // line_end
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,   // [7:0] tx_char
    input logic       m_axis_tlast    // tx_last
);

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // Every answer closes with the prompt space
    a_last_space: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == cmc_pkg::CH_SPACE)
        else $error("answer does not close with a space");

    // A taken line end starts an answer on the next cycle
    a_answer_starts: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=>
            m_axis_tvalid && m_axis_tdata == cmc_pkg::CH_CR)
        else $error("line end gave no answer");

    // No line end is taken while an answer drains
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(s_axis_tvalid && s_axis_tready && s_axis_tlast))
        else $error("line end taken during an answer");

endmodule

bind hex_command_memory_console cmc_checker u_cmc_checker (.*);

/* sim/testbench.sv */
`timescale 1ns / 100ps
// Self-checking bench for hex_command_memory_console: streams command lines
// in, predicts every answer character and checks the answer stream.
// Depends on cmc_pkg and the hex_command_memory_console RTL.

localparam int MEM_DEPTH = cmc_pkg::STORE_DEPTH_DEF;

// One answer character as it should appear on the master side
typedef struct packed {
    logic [7:0] ch;
    logic       fin;
} tx_beat_t;

// Uppercase hex digit to value; lowercase and anything else is rejected
function automatic bit hex_val(input logic [7:0] c, output logic [3:0] v);
    v = 4'd0;
    if (c >= "0" && c <= "9")
    begin
        v = 4'(c - "0");
        return 1'b1;
    end
    if (c >= "A" && c <= "F")
    begin
        v = 4'(c - "A" + 8'd10);
        return 1'b1;
    end
    return 1'b0;
endfunction

function automatic logic [7:0] nib_to_ascii(input logic [3:0] nib);
    return (nib > 4'd9) ? 8'("A" + (nib - 4'd10)) : 8'("0" + nib);
endfunction

class console_scoreboard;
    logic [7:0]                store_img [MEM_DEPTH];
    logic [7:0]                line_img [cmc_pkg::LINE_SLOTS];
    logic [cmc_pkg::CNT_W-1:0] line_len;
    tx_beat_t                  pending [$];
    int unsigned               fail_count;

    function new();
        foreach (store_img[i])
        begin
            store_img[i] = cmc_pkg::ERASED_BYTE;
        end
        line_len   = '0;
        fail_count = 0;
    endfunction

    function void add_answer(input logic [7:0] ch, input logic fin);
        tx_beat_t b;
        b.ch  = ch;
        b.fin = fin;
        pending.push_back(b);
    endfunction

    // Buffer a command character, or decode the line on a line-end beat
    function void note_input(input logic [7:0] c, input logic line_end);
        cmc_pkg::resp_kind_t kind;
        logic [3:0] a3, a2, a1, a0, dh, dl;
        logic [15:0] addr;
        logic [7:0] rd;
        if (!line_end)
        begin
            if (line_len < cmc_pkg::LINE_SLOTS)
            begin
                line_img[line_len] = c;
            end
            if (line_len != cmc_pkg::COUNT_MAX)
            begin
                line_len++;
            end
            return;
        end
        kind = cmc_pkg::RESP_ERR;
        rd   = 8'h00;
        if (line_len == 0)
        begin
            kind = cmc_pkg::RESP_EMPTY;
        end
        else if (line_img[0] == cmc_pkg::CH_E && line_len >= 6 &&
                 line_len <= cmc_pkg::LINE_SLOTS)
        begin
            if (hex_val(line_img[2], a3) && hex_val(line_img[3], a2) &&
                hex_val(line_img[4], a1) && hex_val(line_img[5], a0))
            begin
                addr = {a3, a2, a1, a0};
                if (line_img[1] == cmc_pkg::CH_R && line_len == 6)
                begin
                    if (int'(addr) < MEM_DEPTH)
                    begin
                        rd   = store_img[addr];
                        kind = cmc_pkg::RESP_READ;
                    end
                end
                else if (line_img[1] == cmc_pkg::CH_W && line_len == 9)
                begin
                    // separator at slot 6 is don't-care
                    if (int'(addr) < MEM_DEPTH && hex_val(line_img[7], dh) &&
                        hex_val(line_img[8], dl))
                    begin
                        store_img[addr] = {dh, dl};
                        kind = cmc_pkg::RESP_OK;
                    end
                end
            end
        end
        line_len = '0;

        // Frame: CR LF body CR LF '@' ' '
        add_answer(cmc_pkg::CH_CR, 1'b0);
        add_answer(cmc_pkg::CH_LF, 1'b0);
        case (kind)
            cmc_pkg::RESP_READ:
            begin
                add_answer(nib_to_ascii(rd[7:4]), 1'b0);
                add_answer(nib_to_ascii(rd[3:0]), 1'b0);
            end
            cmc_pkg::RESP_OK:
            begin
                add_answer(cmc_pkg::CH_UP_O, 1'b0);
                add_answer(cmc_pkg::CH_UP_K, 1'b0);
            end
            cmc_pkg::RESP_ERR:
            begin
                add_answer(cmc_pkg::CH_UP_E, 1'b0);
                add_answer(cmc_pkg::CH_R, 1'b0);
                add_answer(cmc_pkg::CH_R, 1'b0);
                add_answer(cmc_pkg::CH_BANG, 1'b0);
            end
            default:
            begin
            end
        endcase
        add_answer(cmc_pkg::CH_CR, 1'b0);
        add_answer(cmc_pkg::CH_LF, 1'b0);
        add_answer(cmc_pkg::CH_AT, 1'b0);
        add_answer(cmc_pkg::CH_SPACE, 1'b1);
    endfunction

    // Compare one answer beat with the oldest expected character
    function void check_result(input logic [7:0] ch, input logic fin);
        tx_beat_t exp_beat;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected answer beat tx_char=%h tx_last=%b", $time, ch, fin);
            fail_count++;
            return;
        end
        exp_beat = pending.pop_front();
        if (ch !== exp_beat.ch)
        begin
            $display("%0t: tx_char mismatch expected=%h actual=%h", $time, exp_beat.ch, ch);
            fail_count++;
        end
        if (fin !== exp_beat.fin)
        begin
            $display("%0t: tx_last mismatch expected=%b actual=%b", $time, exp_beat.fin, fin);
            fail_count++;
        end
    endfunction
endclass

module testbench;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LINE_ITEMS     = 250;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    console_scoreboard sb;
    logic [7:0] line_q [$];
    bit          no_idle = 1'b0;
    int unsigned items_sent = 0;
    int unsigned rx_hold = 0;
    int unsigned idle_cycles = 0;

    hex_command_memory_console #(
        .STORE_DEPTH(MEM_DEPTH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, a few long ones, none during a back-to-back stretch
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Sink side: stall the answer stream at random
    always @(negedge clk)
    begin
        if (rx_hold != 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold       <= rx_hold - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            rx_hold       <= pick_gap();
        end
    end

    // Check every answer beat taken by the sink
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_result(m_axis_tdata, m_axis_tlast);
        end
    end

    // Abort when neither side moves a beat for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, no beat moved", $time);
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one beat after a random gap and hold it until taken
    task automatic send_beat(input logic [7:0] c, input logic line_end);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= line_end;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        sb.note_input(c, line_end);
        items_sent++;
    endtask

    // Send the buffered line and close it; the char on the line-end beat is junk
    task automatic send_line();
        foreach (line_q[i])
        begin
            send_beat(line_q[i], 1'b0);
        end
        send_beat(8'($urandom_range(0, 255)), 1'b1);
        line_q.delete();
    endtask

    // Hold the source idle until every predicted answer has drained
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic push_hex4(input logic [15:0] v);
        line_q.push_back(nib_to_ascii(v[15:12]));
        line_q.push_back(nib_to_ascii(v[11:8]));
        line_q.push_back(nib_to_ascii(v[7:4]));
        line_q.push_back(nib_to_ascii(v[3:0]));
    endtask

    task automatic push_hex2(input logic [7:0] v);
        line_q.push_back(nib_to_ascii(v[7:4]));
        line_q.push_back(nib_to_ascii(v[3:0]));
    endtask

    // Cluster addresses at both ends of the store so writes get read back
    function automatic logic [15:0] pick_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            return 16'($urandom_range(0, 7));
        end
        if (r < 80)
        begin
            return 16'($urandom_range(MEM_DEPTH - 8, MEM_DEPTH - 1));
        end
        if (r < 92)
        begin
            return 16'($urandom_range(0, MEM_DEPTH - 1));
        end
        return 16'($urandom_range(MEM_DEPTH, 65535));
    endfunction

    task automatic build_read();
        line_q.push_back(cmc_pkg::CH_E);
        line_q.push_back(cmc_pkg::CH_R);
        push_hex4(pick_addr());
    endtask

    task automatic build_write();
        line_q.push_back(cmc_pkg::CH_E);
        line_q.push_back(cmc_pkg::CH_W);
        push_hex4(pick_addr());
        line_q.push_back(8'($urandom_range(0, 255)));
        push_hex2(8'($urandom_range(0, 255)));
    endtask

    // Mostly well-formed commands; the rest empty, corrupted, misshapen or noise
    task automatic build_random_line();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            build_read();
        end
        else if (r < 75)
        begin
            build_write();
        end
        else if (r < 80)
        begin
            // empty line: framing only
        end
        else if (r < 87)
        begin
            if ($urandom_range(0, 1)) build_write(); else build_read();
            line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
        end
        else if (r < 93)
        begin
            // wrong length: trim or pad a good command
            if ($urandom_range(0, 1)) build_write(); else build_read();
            if ($urandom_range(0, 1))
            begin
                n = $urandom_range(1, line_q.size() - 1);
                repeat (n) void'(line_q.pop_back());
            end
            else
            begin
                n = $urandom_range(1, 4);
                repeat (n) push_hex2(8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            // overlong line, longer than the line buffer, often past the saturation point of the count
            n = $urandom_range(10, 20);
            repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int line_no;
        sb = new();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Empty line, write at the top address with extreme separator and
        // data, read it back, then read an erased byte
        send_line();
        line_q.push_back(cmc_pkg::CH_E);
        line_q.push_back(cmc_pkg::CH_W);
        push_hex4(16'(MEM_DEPTH - 1));
        line_q.push_back(8'hFF);
        push_hex2(8'h00);
        send_line();
        line_q.push_back(cmc_pkg::CH_E);
        line_q.push_back(cmc_pkg::CH_R);
        push_hex4(16'(MEM_DEPTH - 1));
        send_line();
        line_q.push_back(cmc_pkg::CH_E);
        line_q.push_back(cmc_pkg::CH_R);
        push_hex4(16'h0000);
        send_line();
        wait_drained();

        // Random lines, with one back-to-back stretch and one drain pause
        line_no = 0;
        while (items_sent < LINE_ITEMS)
        begin
            no_idle = (line_no >= 8 && line_no < 13);
            build_random_line();
            send_line();
            if (line_no == 16)
            begin
                wait_drained();
            end
            line_no++;
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
